### design/actuator_timeout_controller_unit_defines.svh
// Assertion macros for the actuator timeout controller.
`ifndef ACTUATOR_TIMEOUT_CONTROLLER_UNIT_DEFINES_SVH
`define ACTUATOR_TIMEOUT_CONTROLLER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Check prop at every clock edge outside reset.
`define ATC_ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("atc assertion failed");

// Check that cons holds in the cycle after ante.
`define ATC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("atc assertion failed");

`else

`define ATC_ASSERT_ALWAYS(label, clk, rst_n, prop)
`define ATC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### design/atc_pkg.sv
`default_nettype none

package atc_pkg;

  localparam int OPCODE_W   = 2;
  localparam int LEVEL_W    = 8;
  localparam int TICKS_W    = 8;
  localparam int PRESCALE_W = 7;
  localparam int PHASE_W    = 4;
  localparam int DRIVE_W    = 16;
  localparam int CFG_W      = 8;
  localparam int CFG_IDX_W  = 1;

  localparam int BLINK_STEPS = 10;
  localparam logic [PHASE_W-1:0] BLINK_LAST  = PHASE_W'(BLINK_STEPS - 1);
  localparam logic [PHASE_W-1:0] LED_PHASE_A = PHASE_W'(0);
  localparam logic [PHASE_W-1:0] LED_PHASE_B = PHASE_W'(2);

  localparam logic [TICKS_W-1:0]    LASER_HOLD_RESET  = TICKS_W'(200);
  localparam logic [PRESCALE_W-1:0] POLL_RELOAD_RESET = PRESCALE_W'(100);

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK     = 2'd0,
    OP_FIRE     = 2'd1,
    OP_LASER    = 2'd2,
    OP_AGITATOR = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LASER_HOLD  = 1'd0,
    CFG_POLL_RELOAD = 1'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [TICKS_W-1:0]    laser_hold_ticks;
    logic [PRESCALE_W-1:0] poll_reload;
  } cfg_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [LEVEL_W-1:0] pwm_level;
    logic [TICKS_W-1:0] fire_ticks;
    logic               laser_on;
    logic               arm_sense;
  } item_t;

  typedef struct packed {
    logic [PRESCALE_W-1:0] prescale_count;
    logic [PHASE_W-1:0]    blink_phase;
    logic [TICKS_W-1:0]    fire_timeout;
    logic [LEVEL_W-1:0]    fire_duty;
    logic [LEVEL_W-1:0]    agitator_duty;
    logic [TICKS_W-1:0]    laser_timeout;
    logic                  laser_state;
    logic                  armed_state;
    logic                  led_state;
  } state_t;

  typedef struct packed {
    logic               drive_enable;
    logic               laser_active;
    logic [DRIVE_W-1:0] fire_drive;
    logic [DRIVE_W-1:0] agitator_drive;
    logic               arm_led;
    logic               armed;
    logic [TICKS_W-1:0] fire_remaining;
  } result_t;

endpackage

`default_nettype wire

### design/atc_step.sv
`default_nettype none

module atc_step (
  input  atc_pkg::state_t  state,
  input  atc_pkg::item_t   item,
  input  atc_pkg::cfg_t    cfg,
  output atc_pkg::state_t  state_nxt,
  output atc_pkg::result_t res
);

  logic [atc_pkg::PHASE_W-1:0] phase_inc;

  assign phase_inc = (state.blink_phase == atc_pkg::BLINK_LAST) ?
                     '0 : state.blink_phase + atc_pkg::PHASE_W'(1);

  always_comb begin
    state_nxt = state;
    case (item.opcode)
      atc_pkg::OP_TICK: begin
        if (state.prescale_count == '0) begin
          state_nxt.prescale_count = cfg.poll_reload;
          state_nxt.armed_state    = item.arm_sense;
          state_nxt.blink_phase    = phase_inc;
          state_nxt.led_state      = item.arm_sense &
                                     ((phase_inc == atc_pkg::LED_PHASE_A) ||
                                      (phase_inc == atc_pkg::LED_PHASE_B));
          if (state.fire_timeout != '0) begin
            state_nxt.fire_timeout = state.fire_timeout - atc_pkg::TICKS_W'(1);
          end else begin
            state_nxt.fire_duty = '0;
          end
          if (state.laser_timeout != '0) begin
            state_nxt.laser_timeout = state.laser_timeout - atc_pkg::TICKS_W'(1);
          end else begin
            state_nxt.agitator_duty = '0;
            state_nxt.laser_state   = 1'b0;
          end
        end else begin
          state_nxt.prescale_count = state.prescale_count - atc_pkg::PRESCALE_W'(1);
        end
      end
      atc_pkg::OP_FIRE: begin
        state_nxt.fire_timeout = item.fire_ticks;
        state_nxt.fire_duty    = item.pwm_level;
      end
      atc_pkg::OP_LASER: begin
        state_nxt.laser_state   = item.laser_on;
        state_nxt.laser_timeout = cfg.laser_hold_ticks;
      end
      atc_pkg::OP_AGITATOR: begin
        state_nxt.agitator_duty = item.pwm_level;
      end
      default: begin
        state_nxt = state;
      end
    endcase
  end

  // x257 is the byte repeated in both halves
  always_comb begin
    res.drive_enable   = (state_nxt.fire_duty != '0) || (state_nxt.agitator_duty != '0);
    res.laser_active   = state_nxt.laser_state;
    res.fire_drive     = {state_nxt.fire_duty, state_nxt.fire_duty};
    res.agitator_drive = {state_nxt.agitator_duty, state_nxt.agitator_duty};
    res.arm_led        = state_nxt.led_state;
    res.armed          = state_nxt.armed_state;
    res.fire_remaining = state_nxt.fire_timeout;
  end

endmodule

`default_nettype wire

### design/actuator_timeout_controller_unit.sv
// Channel   Handshake             Payload
// in        in_valid / in_stall   opcode, pwm_level, fire_ticks, laser_on, arm_sense
// out       out_valid / out_stall drive_enable, laser_active, fire_drive,
//                                 agitator_drive, arm_led, armed, fire_remaining
// cfg       cfg_wr_en             cfg_index, cfg_wdata
//
// One item per cycle while out_stall is low; an accepted item passes through the input
// register, then the result register, where its result is valid and can transfer.
// Reset (synchronous, rst_n low) clears all state and loads the register defaults.
// A stalled result holds; one more item waits in the input register, then in_stall rises.
`default_nettype none
`include "actuator_timeout_controller_unit_defines.svh"

module actuator_timeout_controller_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [atc_pkg::OPCODE_W-1:0]  in_opcode,
  input  wire logic [atc_pkg::LEVEL_W-1:0]   in_pwm_level,
  input  wire logic [atc_pkg::TICKS_W-1:0]   in_fire_ticks,
  input  wire logic                          in_laser_on,
  input  wire logic                          in_arm_sense,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_drive_enable,
  output logic                               out_laser_active,
  output logic [atc_pkg::DRIVE_W-1:0]        out_fire_drive,
  output logic [atc_pkg::DRIVE_W-1:0]        out_agitator_drive,
  output logic                               out_arm_led,
  output logic                               out_armed,
  output logic [atc_pkg::TICKS_W-1:0]        out_fire_remaining,
  input  wire logic                          cfg_wr_en,
  input  wire logic [atc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [atc_pkg::CFG_W-1:0]     cfg_wdata
);

  atc_pkg::cfg_t    cfg_r;
  atc_pkg::item_t   in_item_r;
  logic             in_valid_r;
  atc_pkg::state_t  state_r;
  atc_pkg::state_t  state_nxt;
  atc_pkg::result_t res_nxt;
  atc_pkg::result_t out_res_r;
  logic             out_valid_r;
  logic             advance;
  logic             in_xfer;

  assign advance  = in_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = in_valid_r & out_valid_r & out_stall;
  assign in_xfer  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.laser_hold_ticks <= atc_pkg::LASER_HOLD_RESET;
      cfg_r.poll_reload      <= atc_pkg::POLL_RELOAD_RESET;
    end else if (cfg_wr_en) begin
      case (atc_pkg::cfg_idx_t'(cfg_index))
        atc_pkg::CFG_LASER_HOLD:  cfg_r.laser_hold_ticks <= cfg_wdata;
        atc_pkg::CFG_POLL_RELOAD: cfg_r.poll_reload <= cfg_wdata[atc_pkg::PRESCALE_W-1:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_xfer) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_item_r.opcode     <= atc_pkg::opcode_t'(in_opcode);
      in_item_r.pwm_level  <= in_pwm_level;
      in_item_r.fire_ticks <= in_fire_ticks;
      in_item_r.laser_on   <= in_laser_on;
      in_item_r.arm_sense  <= in_arm_sense;
    end
  end

  atc_step u_step (
    .state     (state_r),
    .item      (in_item_r),
    .cfg       (cfg_r),
    .state_nxt (state_nxt),
    .res       (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_drive_enable   = out_res_r.drive_enable;
  assign out_laser_active   = out_res_r.laser_active;
  assign out_fire_drive     = out_res_r.fire_drive;
  assign out_agitator_drive = out_res_r.agitator_drive;
  assign out_arm_led        = out_res_r.arm_led;
  assign out_armed          = out_res_r.armed;
  assign out_fire_remaining = out_res_r.fire_remaining;

  `ATC_ASSERT_ALWAYS(a_phase_range, clk, rst_n, state_r.blink_phase <= atc_pkg::BLINK_LAST)
  `ATC_ASSERT_ALWAYS(a_led_armed, clk, rst_n, !state_r.led_state || state_r.armed_state)
  `ATC_ASSERT_NEXT(a_held_item, clk, rst_n, in_valid_r && !advance, in_valid_r)
  `ATC_ASSERT_NEXT(a_result_shown, clk, rst_n, advance,
                   out_valid_r && out_fire_remaining == state_r.fire_timeout)

endmodule

`default_nettype wire

### bench/testbench.sv
`default_nettype none

module testbench;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 6;
  localparam logic [atc_pkg::DRIVE_W-1:0] DRIVE_SCALE = atc_pkg::DRIVE_W'(257);

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  logic [atc_pkg::OPCODE_W-1:0] in_opcode = '0;
  logic [atc_pkg::LEVEL_W-1:0] in_pwm_level = '0;
  logic [atc_pkg::TICKS_W-1:0] in_fire_ticks = '0;
  logic in_laser_on = 1'b0;
  logic in_arm_sense = 1'b0;

  logic out_valid;
  logic out_stall = 1'b0;
  logic out_drive_enable;
  logic out_laser_active;
  logic [atc_pkg::DRIVE_W-1:0] out_fire_drive;
  logic [atc_pkg::DRIVE_W-1:0] out_agitator_drive;
  logic out_arm_led;
  logic out_armed;
  logic [atc_pkg::TICKS_W-1:0] out_fire_remaining;

  logic cfg_wr_en = 1'b0;
  logic [atc_pkg::CFG_IDX_W-1:0] cfg_index = atc_pkg::CFG_LASER_HOLD;
  logic [atc_pkg::CFG_W-1:0] cfg_wdata = '0;

  actuator_timeout_controller_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_opcode(in_opcode),
    .in_pwm_level(in_pwm_level),
    .in_fire_ticks(in_fire_ticks),
    .in_laser_on(in_laser_on),
    .in_arm_sense(in_arm_sense),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_drive_enable(out_drive_enable),
    .out_laser_active(out_laser_active),
    .out_fire_drive(out_fire_drive),
    .out_agitator_drive(out_agitator_drive),
    .out_arm_led(out_arm_led),
    .out_armed(out_armed),
    .out_fire_remaining(out_fire_remaining),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  atc_pkg::item_t command_queue[$];
  atc_pkg::result_t predicted_status[$];
  atc_pkg::state_t ctl;
  atc_pkg::cfg_t regs;

  atc_pkg::item_t next_cmd;
  atc_pkg::item_t seen_cmd;
  atc_pkg::result_t want;
  bit in_taken = 1'b0;
  bit out_taken;
  bit mismatch_seen = 1'b0;
  bit arm_level = 1'b0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned quiet_cycles = 0;

  function automatic void slow_poll(logic sw);
    ctl.armed_state = sw;
    ctl.blink_phase = (ctl.blink_phase == atc_pkg::BLINK_LAST) ? '0 : ctl.blink_phase + 1'b1;
    ctl.led_state = sw && (ctl.blink_phase == atc_pkg::LED_PHASE_A ||
                           ctl.blink_phase == atc_pkg::LED_PHASE_B);
    if (ctl.fire_timeout != '0) begin
      ctl.fire_timeout = ctl.fire_timeout - 1'b1;
    end else begin
      ctl.fire_duty = '0;
    end
    if (ctl.laser_timeout != '0) begin
      ctl.laser_timeout = ctl.laser_timeout - 1'b1;
    end else begin
      ctl.agitator_duty = '0;
      ctl.laser_state = 1'b0;
    end
  endfunction

  function automatic atc_pkg::result_t apply_command(atc_pkg::item_t c);
    atc_pkg::result_t r;
    case (c.opcode)
      atc_pkg::OP_TICK: begin
        if (ctl.prescale_count == '0) begin
          ctl.prescale_count = regs.poll_reload;
          slow_poll(c.arm_sense);
        end else begin
          ctl.prescale_count = ctl.prescale_count - 1'b1;
        end
      end
      atc_pkg::OP_FIRE: begin
        ctl.fire_timeout = c.fire_ticks;
        ctl.fire_duty = c.pwm_level;
      end
      atc_pkg::OP_LASER: begin
        ctl.laser_state = c.laser_on;
        ctl.laser_timeout = regs.laser_hold_ticks;
      end
      default: begin
        ctl.agitator_duty = c.pwm_level;
      end
    endcase
    r.drive_enable = (ctl.fire_duty != '0) || (ctl.agitator_duty != '0);
    r.laser_active = ctl.laser_state;
    r.fire_drive = atc_pkg::DRIVE_W'(ctl.fire_duty) * DRIVE_SCALE;
    r.agitator_drive = atc_pkg::DRIVE_W'(ctl.agitator_duty) * DRIVE_SCALE;
    r.arm_led = ctl.led_state;
    r.armed = ctl.armed_state;
    r.fire_remaining = ctl.fire_timeout;
    return r;
  endfunction

  function automatic atc_pkg::item_t make_cmd(atc_pkg::opcode_t op,
                                              logic [atc_pkg::LEVEL_W-1:0] level,
                                              logic [atc_pkg::TICKS_W-1:0] ticks,
                                              logic laser, logic sw);
    atc_pkg::item_t c;
    c.opcode = op;
    c.pwm_level = level;
    c.fire_ticks = ticks;
    c.laser_on = laser;
    c.arm_sense = sw;
    return c;
  endfunction

  function automatic atc_pkg::item_t random_command();
    atc_pkg::item_t c;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 55) begin
      c.opcode = atc_pkg::OP_TICK;
    end else if (pick < 70) begin
      c.opcode = atc_pkg::OP_FIRE;
    end else if (pick < 85) begin
      c.opcode = atc_pkg::OP_LASER;
    end else begin
      c.opcode = atc_pkg::OP_AGITATOR;
    end
    case ($urandom_range(3))
      0: c.pwm_level = '0;
      1: c.pwm_level = '1;
      default: c.pwm_level = atc_pkg::LEVEL_W'($urandom_range(255));
    endcase
    if ($urandom_range(3) == 0) begin
      c.fire_ticks = atc_pkg::TICKS_W'($urandom_range(255));
    end else begin
      c.fire_ticks = atc_pkg::TICKS_W'($urandom_range(6));
    end
    c.laser_on = 1'($urandom_range(1));
    // keep the switch level sticky so the blink pattern gets exercised
    if ($urandom_range(99) < 15) begin
      arm_level = !arm_level;
    end
    c.arm_sense = arm_level;
    return c;
  endfunction

  task automatic check_field(string field, logic [atc_pkg::DRIVE_W-1:0] got,
                             logic [atc_pkg::DRIVE_W-1:0] exp_v);
    if (got !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, exp_v, got);
      mismatch_seen = 1'b1;
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (command_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_cmd = command_queue.pop_front();
        in_valid <= 1'b1;
        in_opcode <= next_cmd.opcode;
        in_pwm_level <= next_cmd.pwm_level;
        in_fire_ticks <= next_cmd.fire_ticks;
        in_laser_on <= next_cmd.laser_on;
        in_arm_sense <= next_cmd.arm_sense;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && !in_stall;
    out_taken = rst_n && out_valid && !out_stall;
    if (rst_n && cfg_wr_en) begin
      case (atc_pkg::cfg_idx_t'(cfg_index))
        atc_pkg::CFG_LASER_HOLD: regs.laser_hold_ticks = cfg_wdata;
        default: regs.poll_reload = cfg_wdata[atc_pkg::PRESCALE_W-1:0];
      endcase
    end
    if (out_taken) begin
      if (predicted_status.size() == 0) begin
        $display("%0t: result transfer with nothing expected", $time);
        mismatch_seen = 1'b1;
      end else begin
        want = predicted_status.pop_front();
        check_field("drive_enable", atc_pkg::DRIVE_W'(out_drive_enable),
                    atc_pkg::DRIVE_W'(want.drive_enable));
        check_field("laser_active", atc_pkg::DRIVE_W'(out_laser_active),
                    atc_pkg::DRIVE_W'(want.laser_active));
        check_field("fire_drive", out_fire_drive, want.fire_drive);
        check_field("agitator_drive", out_agitator_drive, want.agitator_drive);
        check_field("arm_led", atc_pkg::DRIVE_W'(out_arm_led), atc_pkg::DRIVE_W'(want.arm_led));
        check_field("armed", atc_pkg::DRIVE_W'(out_armed), atc_pkg::DRIVE_W'(want.armed));
        check_field("fire_remaining", atc_pkg::DRIVE_W'(out_fire_remaining),
                    atc_pkg::DRIVE_W'(want.fire_remaining));
      end
    end
    if (in_taken) begin
      seen_cmd = make_cmd(atc_pkg::opcode_t'(in_opcode), in_pwm_level, in_fire_ticks,
                          in_laser_on, in_arm_sense);
      predicted_status.push_back(apply_command(seen_cmd));
    end
    if (rst_n) begin
      if (in_taken || out_taken || cfg_wr_en) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  task automatic wait_idle();
    while (command_queue.size() != 0 || in_valid || predicted_status.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(atc_pkg::cfg_idx_t idx, logic [atc_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic run_phase(int hold, int reload, int unsigned idle_pct,
                           int unsigned stall_pct, int count, bit with_directed);
    wait_idle();
    write_register(atc_pkg::CFG_LASER_HOLD, atc_pkg::CFG_W'(hold));
    write_register(atc_pkg::CFG_POLL_RELOAD, atc_pkg::CFG_W'(reload));
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    if (with_directed) begin
      command_queue.push_back(make_cmd(atc_pkg::OP_TICK, 8'h00, 8'h00, 1'b0, 1'b0));
      command_queue.push_back(make_cmd(atc_pkg::OP_FIRE, 8'hFF, 8'hFF, 1'b0, 1'b0));
      command_queue.push_back(make_cmd(atc_pkg::OP_TICK, 8'h00, 8'h00, 1'b0, 1'b1));
      command_queue.push_back(make_cmd(atc_pkg::OP_FIRE, 8'h00, 8'h00, 1'b0, 1'b1));
      command_queue.push_back(make_cmd(atc_pkg::OP_FIRE, 8'h01, 8'h02, 1'b0, 1'b1));
      repeat (3) command_queue.push_back(make_cmd(atc_pkg::OP_TICK, 8'h00, 8'h00, 1'b0, 1'b1));
      command_queue.push_back(make_cmd(atc_pkg::OP_LASER, 8'h00, 8'h00, 1'b1, 1'b0));
      command_queue.push_back(make_cmd(atc_pkg::OP_AGITATOR, 8'hFF, 8'h00, 1'b0, 1'b0));
      repeat (5) command_queue.push_back(make_cmd(atc_pkg::OP_TICK, 8'h00, 8'h00, 1'b0, 1'b1));
      command_queue.push_back(make_cmd(atc_pkg::OP_LASER, 8'hFF, 8'hFF, 1'b0, 1'b1));
      command_queue.push_back(make_cmd(atc_pkg::OP_AGITATOR, 8'h80, 8'hFF, 1'b1, 1'b1));
      command_queue.push_back(make_cmd(atc_pkg::OP_AGITATOR, 8'h00, 8'h00, 1'b0, 1'b0));
      command_queue.push_back(make_cmd(atc_pkg::OP_TICK, 8'hFF, 8'hFF, 1'b1, 1'b1));
      command_queue.push_back(make_cmd(atc_pkg::OP_LASER, 8'hAA, 8'h55, 1'b1, 1'b0));
      command_queue.push_back(make_cmd(atc_pkg::OP_FIRE, 8'h55, 8'hAA, 1'b1, 1'b1));
      repeat (4) command_queue.push_back(make_cmd(atc_pkg::OP_TICK, 8'h00, 8'h00, 1'b0, 1'b0));
    end
    repeat (count) command_queue.push_back(random_command());
  endtask

  initial begin
    ctl = '0;
    regs.laser_hold_ticks = atc_pkg::LASER_HOLD_RESET;
    regs.poll_reload = atc_pkg::POLL_RELOAD_RESET;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    run_phase(3, 0, 0, 0, 190, 1'b1);
    run_phase(0, 1, 88, 0, 210, 1'b0);
    run_phase(255, 0, 0, 88, 210, 1'b0);
    run_phase(7, 127, 28, 28, 210, 1'b0);
    run_phase(1, 2, 0, 0, 210, 1'b0);
    run_phase(20, 0, 88, 0, 210, 1'b0);
    run_phase(2, 3, 0, 88, 210, 1'b0);
    run_phase(200, 100, 28, 28, 210, 1'b0);
    wait_idle();
    if (!mismatch_seen) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
